/* rtl/sscs_pkg.sv */
// shared types and constants for the sparse-set component store
`default_nettype none

package sscs_pkg;

	// fixed field widths of the request and result payloads
	localparam int FUNC_W   = 2;
	localparam int ID_W     = 10;
	localparam int DIN_W    = 32;
	localparam int STATUS_W = 2;
	localparam int DOUT_W   = 32;
	localparam int CNT_W    = 11;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   ent_id;
		logic [DIN_W-1:0]  data_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [DOUT_W-1:0]   data_out;
		logic [CNT_W-1:0]    entry_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_UNMAP,
		ST_LOOK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* rtl/sparse_set_component_store_unit.sv */
// sparse-set component store: sparse map, packed entity and data arrays, sequencer
`default_nettype none

// Sparse-set store holding one data word per entity id. After reset the block
// sweeps the sparse map to empty, one entry per cycle, with req_stall high.
// After that one request is worked at a time: each goes from IDLE through EVAL
// to DONE, a remove that finds its entity passing through UNMAP and a lookup
// that finds its entity through LOOK on the way; the result enters the output
// register in DONE. The sequence is set by the single write port of the sparse
// map and its registered read: remove reads the map and the last packed entry,
// then writes the moved entry's back-link and clears the removed entity in two
// separate map writes; lookup needs a dependent read of the packed data. The
// output register lets the next request be accepted while a finished result
// still waits to be taken; a result still stalled at the output holds the
// following one back in DONE.
module sparse_set_component_store_unit #(
	parameter int MAX_ENTITIES = 1024,
	parameter int DATA_WIDTH   = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire sscs_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output sscs_pkg::res_t      res
);

	localparam int IW = $clog2(MAX_ENTITIES);
	localparam int CW = $clog2(MAX_ENTITIES + 1);
	localparam logic [IW-1:0] LAST_IX = IW'(MAX_ENTITIES - 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTITIES);

	// memories
	logic [IW:0]           map_mem [MAX_ENTITIES];
	logic [IW-1:0]         ent_mem [MAX_ENTITIES];
	logic [DATA_WIDTH-1:0] dat_mem [MAX_ENTITIES];

	// control state
	sscs_pkg::state_t state_q, state_d;
	logic [IW-1:0]    clr_q;
	logic [CW-1:0]    count_q;
	logic             res_valid_q;

	// request and read registers
	logic [sscs_pkg::FUNC_W-1:0]   func_q;
	logic [sscs_pkg::ID_W-1:0]     id_q;
	logic [DATA_WIDTH-1:0]         word_q;
	logic [IW:0]                   map_rd_q;
	logic [IW-1:0]                 ent_rd_q;
	logic [DATA_WIDTH-1:0]         dat_rd_q;
	logic [sscs_pkg::STATUS_W-1:0] status_q;
	logic                          found_q;
	logic [sscs_pkg::DOUT_W-1:0]   data_q;
	sscs_pkg::res_t                res_q;

	// derived values
	logic                  accept;
	logic [16:0]           req_ext, id_ext;
	logic [IW-1:0]         req_ix, id_ix, count_ix, last_ix, map_slot;
	logic [CW-1:0]         last_c;
	logic                  id_ok, map_valid, present, cnt_zero, cnt_full;
	logic [63:0]           din_ext, dat_ext;
	logic [31:0]           cnt_ext;

	// memory port controls
	logic                  map_we, ent_we, dat_we, dat_ren;
	logic [IW-1:0]         map_waddr, ent_waddr, dat_waddr, dat_raddr;
	logic [IW:0]           map_wdata;
	logic [IW-1:0]         ent_wdata;
	logic [DATA_WIDTH-1:0] dat_wdata;
	logic                  cnt_inc, cnt_dec, status_ld, found_clr, found_ld, out_ld;
	logic [sscs_pkg::STATUS_W-1:0] status_d;

	// handshake
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != sscs_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// index and width conversions
	assign req_ext   = 17'(req.ent_id);
	assign req_ix    = req_ext[IW-1:0];
	assign id_ext    = 17'(id_q);
	assign id_ix     = id_ext[IW-1:0];
	assign count_ix  = count_q[IW-1:0];
	assign last_c    = count_q - CW'(1);
	assign last_ix   = last_c[IW-1:0];
	assign din_ext   = 64'(req.data_in);
	assign dat_ext   = 64'(dat_rd_q);
	assign cnt_ext   = 32'(count_q);

	// lookup of the captured request against the sparse map
	assign id_ok     = (32'(id_q) < 32'(MAX_ENTITIES));
	assign map_valid = map_rd_q[IW];
	assign map_slot  = map_rd_q[IW-1:0];
	assign present   = id_ok && map_valid;
	assign cnt_zero  = (count_q == '0);
	assign cnt_full  = (count_q >= MAX_CNT);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sscs_pkg::ST_CLEAR: begin
				if (clr_q == LAST_IX) state_d = sscs_pkg::ST_IDLE;
			end
			sscs_pkg::ST_IDLE: begin
				if (req_valid) state_d = sscs_pkg::ST_EVAL;
			end
			sscs_pkg::ST_EVAL: begin
				if (func_q == sscs_pkg::FUNC_LOOKUP && present) begin
					state_d = sscs_pkg::ST_LOOK;
				end else if (func_q == sscs_pkg::FUNC_REMOVE && present && !cnt_zero) begin
					state_d = sscs_pkg::ST_UNMAP;
				end else begin
					state_d = sscs_pkg::ST_DONE;
				end
			end
			sscs_pkg::ST_UNMAP: state_d = sscs_pkg::ST_DONE;
			sscs_pkg::ST_LOOK:  state_d = sscs_pkg::ST_DONE;
			sscs_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) state_d = sscs_pkg::ST_IDLE;
			end
			default: state_d = sscs_pkg::ST_CLEAR;
		endcase
	end

	// memory accesses and result loads per state
	always_comb begin
		map_we    = 1'b0;
		map_waddr = id_ix;
		map_wdata = '0;
		ent_we    = 1'b0;
		ent_waddr = count_ix;
		ent_wdata = id_ix;
		dat_we    = 1'b0;
		dat_waddr = count_ix;
		dat_wdata = word_q;
		dat_ren   = 1'b0;
		dat_raddr = last_ix;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		status_ld = 1'b0;
		status_d  = sscs_pkg::STATUS_OK;
		found_clr = 1'b0;
		found_ld  = 1'b0;
		out_ld    = 1'b0;
		case (state_q)
			sscs_pkg::ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
			end
			sscs_pkg::ST_IDLE: begin
				dat_ren = 1'b1;
			end
			sscs_pkg::ST_EVAL: begin
				status_ld = 1'b1;
				found_clr = 1'b1;
				dat_ren   = 1'b1;
				dat_raddr = map_slot;
				case (func_q)
					sscs_pkg::FUNC_INSERT: begin
						if (!id_ok) begin
							status_d = sscs_pkg::STATUS_ABSENT;
						end else if (map_valid || cnt_full) begin
							status_d = sscs_pkg::STATUS_PRESENT;
						end else begin
							// append at the end of the packed arrays
							map_we    = 1'b1;
							map_wdata = {1'b1, count_ix};
							ent_we    = 1'b1;
							dat_we    = 1'b1;
							cnt_inc   = 1'b1;
						end
					end
					sscs_pkg::FUNC_REMOVE: begin
						if (!present || cnt_zero) begin
							status_d = sscs_pkg::STATUS_ABSENT;
						end else begin
							// move the last entry into the hole and fix its back-link
							dat_we    = 1'b1;
							dat_waddr = map_slot;
							dat_wdata = dat_rd_q;
							ent_we    = 1'b1;
							ent_waddr = map_slot;
							ent_wdata = ent_rd_q;
							map_we    = 1'b1;
							map_waddr = ent_rd_q;
							map_wdata = {1'b1, map_slot};
							cnt_dec   = 1'b1;
						end
					end
					default: begin
						status_d = sscs_pkg::STATUS_OK;
					end
				endcase
			end
			sscs_pkg::ST_UNMAP: begin
				// mark the removed entity empty after the back-link fix
				map_we = 1'b1;
			end
			sscs_pkg::ST_LOOK: begin
				found_ld = 1'b1;
			end
			sscs_pkg::ST_DONE: begin
				out_ld = !res_valid_q || !res_stall;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sscs_pkg::ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sscs_pkg::ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= last_c;
			end
			if (out_ld) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			id_q   <= req.ent_id;
			word_q <= din_ext[DATA_WIDTH-1:0];
		end
		if (status_ld) status_q <= status_d;
		if (found_clr) begin
			found_q <= 1'b0;
			data_q  <= '0;
		end else if (found_ld) begin
			found_q <= 1'b1;
			data_q  <= dat_ext[sscs_pkg::DOUT_W-1:0];
		end
		if (out_ld) begin
			res_q.status      <= status_q;
			res_q.found       <= found_q;
			res_q.data_out    <= data_q;
			res_q.entry_count <= cnt_ext[sscs_pkg::CNT_W-1:0];
		end
	end

	// sparse map memory
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (accept) map_rd_q <= map_mem[req_ix];
	end

	// packed entity memory
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (accept) ent_rd_q <= ent_mem[last_ix];
	end

	// packed data memory
	always_ff @(posedge clk) begin
		if (dat_we) dat_mem[dat_waddr] <= dat_wdata;
		if (dat_ren) dat_rd_q <= dat_mem[dat_raddr];
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count above capacity");

	a_count_only_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sscs_pkg::ST_EVAL) |=> $stable(count_q))
		else $error("entry count changed outside evaluation");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == sscs_pkg::ST_EVAL))
		else $error("accepted request did not start evaluation");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |=> (res_valid_q && state_q == sscs_pkg::ST_IDLE))
		else $error("result load did not show a valid result");

endmodule

`default_nettype wire
